// ----- design/bafp_pkg.sv -----
// Package: widths, angle constants and arctangent table for the bearing pipeline.
`timescale 1ns / 1ps
package bafp_pkg;

   localparam int COORD_BITS   = 16;
   localparam int CORDIC_STEPS = 16;

   // fraction bits below the integer coordinate; the difference sits at the top of a
   // 60-bit scale, and later shifts truncate towards minus infinity
   localparam int FRAC      = 60 - COORD_BITS;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int XY_BITS   = DIFF_BITS + 2 + FRAC;

   localparam int ANG_BITS  = 32;
   localparam int ANG_FRAC  = 28;
   localparam int OUT_FRAC  = 13;
   localparam int OUT_BITS  = 16;
   localparam int RND_SHIFT = ANG_FRAC - OUT_FRAC;

   localparam int TABLE_LEN = 24;
   localparam int IDX_BITS  = $clog2(TABLE_LEN);

   // front stage, one stage per micro-rotation, rounding stage
   localparam int NSTG = CORDIC_STEPS + 2;

   localparam logic signed [ANG_BITS-1:0] ANG_PI      = 32'sd843314856;
   localparam logic signed [ANG_BITS-1:0] ANG_HALF_PI = 32'sd421657428;
   localparam logic signed [OUT_BITS-1:0] PI_Q13      = 16'sd25736;
   localparam logic signed [OUT_BITS-1:0] HALF_PI_Q13 = 16'sd12868;

   typedef struct packed {
      logic                       special;
      logic signed [XY_BITS-1:0]  x;
      logic signed [XY_BITS-1:0]  y;
      logic signed [ANG_BITS-1:0] z;
   } cordic_word_type;

   // atan(2^-i) in units of 2^-28 rad
   function automatic logic signed [ANG_BITS-1:0] atan_units(input logic [IDX_BITS-1:0] i);
      logic signed [ANG_BITS-1:0] a;
      case (i)
         5'd0:    a = 32'sd210828714;
         5'd1:    a = 32'sd124459457;
         5'd2:    a = 32'sd65760959;
         5'd3:    a = 32'sd33381290;
         5'd4:    a = 32'sd16755422;
         5'd5:    a = 32'sd8385879;
         5'd6:    a = 32'sd4193963;
         5'd7:    a = 32'sd2097109;
         5'd8:    a = 32'sd1048571;
         5'd9:    a = 32'sd524287;
         5'd10:   a = 32'sd262144;
         5'd11:   a = 32'sd131072;
         5'd12:   a = 32'sd65536;
         5'd13:   a = 32'sd32768;
         5'd14:   a = 32'sd16384;
         5'd15:   a = 32'sd8192;
         5'd16:   a = 32'sd4096;
         5'd17:   a = 32'sd2048;
         5'd18:   a = 32'sd1024;
         5'd19:   a = 32'sd512;
         5'd20:   a = 32'sd256;
         5'd21:   a = 32'sd128;
         5'd22:   a = 32'sd64;
         5'd23:   a = 32'sd32;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- design/bafp_front.sv -----
// Front stage: coordinate differences, special angles and half-plane fold.
`timescale 1ns / 1ps
module bafp_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic                                   valid_in,
   input  logic signed [bafp_pkg::COORD_BITS-1:0] parent_x,
   input  logic signed [bafp_pkg::COORD_BITS-1:0] parent_y,
   input  logic signed [bafp_pkg::COORD_BITS-1:0] child_x,
   input  logic signed [bafp_pkg::COORD_BITS-1:0] child_y,
   output logic                                   valid_ff,
   output bafp_pkg::cordic_word_type              word_ff
);
   import bafp_pkg::*;

   logic signed [DIFF_BITS-1:0] dx, dy;
   logic signed [XY_BITS-1:0]   dx_w, dy_w;
   cordic_word_type             word_in;

   assign dx = {child_x[COORD_BITS-1], child_x} - {parent_x[COORD_BITS-1], parent_x};
   assign dy = {child_y[COORD_BITS-1], child_y} - {parent_y[COORD_BITS-1], parent_y};

   assign dx_w = {{2{dx[DIFF_BITS-1]}}, dx, {FRAC{1'b0}}};
   assign dy_w = {{2{dy[DIFF_BITS-1]}}, dy, {FRAC{1'b0}}};

   always_comb begin
      word_in.special = 1'b0;
      word_in.x       = dy_w;
      word_in.y       = dx_w;
      word_in.z       = '0;
      if (dx == '0) begin
         word_in.special = 1'b1;
         word_in.z       = (dy > 0) ? '0 : ANG_PI;
      end else if (dy == '0) begin
         word_in.special = 1'b1;
         word_in.z       = (dx > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
      end else if (dy < 0) begin
         // rotate by pi into the right half plane
         word_in.x = -dy_w;
         word_in.y = -dx_w;
         word_in.z = (dx > 0) ? ANG_PI : -ANG_PI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

endmodule

// ----- design/bafp_stage.sv -----
// One vectoring micro-rotation with its pipeline register.
`timescale 1ns / 1ps
module bafp_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic [bafp_pkg::IDX_BITS-1:0]        idx,
   input  logic                                 valid_in,
   input  bafp_pkg::cordic_word_type            word_in,
   output logic                                 valid_ff,
   output bafp_pkg::cordic_word_type            word_ff
);
   import bafp_pkg::*;

   logic signed [XY_BITS-1:0]  xs, ys;
   logic signed [ANG_BITS-1:0] ang;
   cordic_word_type            word_nx_in;

   assign xs  = word_in.x >>> idx;
   assign ys  = word_in.y >>> idx;
   assign ang = atan_units(idx);

   always_comb begin
      word_nx_in.special = word_in.special;
      if (word_in.y > 0) begin
         word_nx_in.x = word_in.x + ys;
         word_nx_in.y = word_in.y - xs;
         word_nx_in.z = word_in.z + ang;
      end else begin
         word_nx_in.x = word_in.x - ys;
         word_nx_in.y = word_in.y + xs;
         word_nx_in.z = word_in.z - ang;
      end
      // special angles pass through untouched
      if (word_in.special) begin
         word_nx_in.z = word_in.z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_nx_in;
      end
   end

endmodule

// ----- design/bafp_round.sv -----
// Output stage: round the internal angle to Q3.13, ties away from zero.
`timescale 1ns / 1ps
module bafp_round (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic                                 valid_in,
   input  logic signed [bafp_pkg::ANG_BITS-1:0] z,
   output logic                                 valid_ff,
   output logic signed [bafp_pkg::OUT_BITS-1:0] bearing_ff
);
   import bafp_pkg::*;

   logic                       neg;
   logic [ANG_BITS:0]          mag;
   logic [ANG_BITS:0]          rnd;
   logic signed [OUT_BITS-1:0] q;

   assign neg = z[ANG_BITS-1];
   assign mag = neg ? -{z[ANG_BITS-1], z} : {z[ANG_BITS-1], z};
   assign rnd = (mag + (ANG_BITS + 1)'(1 << (RND_SHIFT - 1))) >> RND_SHIFT;
   assign q   = neg ? -rnd[OUT_BITS-1:0] : rnd[OUT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bearing_ff <= q;
      end
   end

endmodule

// ----- design/bearing_angle_from_points_top.sv -----
// Throughput: one word per cycle while req_stall is low; one register stage per micro-rotation plus front and
// rounding stages, and an empty stage takes a new word even while rsp is stalled.
// Reset: synchronous, active high; clears every stage valid bit, data registers keep
// their contents. No state survives between words.
`timescale 1ns / 1ps
module bearing_angle_from_points_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [bafp_pkg::COORD_BITS-1:0] req_parent_x,
   input  logic signed [bafp_pkg::COORD_BITS-1:0] req_parent_y,
   input  logic signed [bafp_pkg::COORD_BITS-1:0] req_child_x,
   input  logic signed [bafp_pkg::COORD_BITS-1:0] req_child_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [bafp_pkg::OUT_BITS-1:0]   rsp_bearing
);
   import bafp_pkg::*;

   logic [NSTG-1:0] vld;
   logic [NSTG-1:0] adv;
   cordic_word_type word [CORDIC_STEPS+1];

   // a stage may load when it or any later stage holds a bubble or the output drains
   genvar k;
   generate
      for (k = 0; k < NSTG; k++) begin : g_adv
         assign adv[k] = !rsp_stall || !(&vld[NSTG-1:k]);
      end
   endgenerate

   assign req_stall = !adv[0];

   bafp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .load     (adv[0]),
      .valid_in (req_valid),
      .parent_x (req_parent_x),
      .parent_y (req_parent_y),
      .child_x  (req_child_x),
      .child_y  (req_child_y),
      .valid_ff (vld[0]),
      .word_ff  (word[0])
   );

   genvar g;
   generate
      for (g = 0; g < CORDIC_STEPS; g++) begin : g_stage
         bafp_stage u_stage (
            .clock    (clock),
            .reset    (reset),
            .load     (adv[g+1]),
            .idx      (IDX_BITS'(g)),
            .valid_in (vld[g]),
            .word_in  (word[g]),
            .valid_ff (vld[g+1]),
            .word_ff  (word[g+1])
         );
      end
   endgenerate

   bafp_round u_round (
      .clock      (clock),
      .reset      (reset),
      .load       (adv[NSTG-1]),
      .valid_in   (vld[NSTG-2]),
      .z          (word[CORDIC_STEPS].z),
      .valid_ff   (vld[NSTG-1]),
      .bearing_ff (rsp_bearing)
   );

   assign rsp_valid = vld[NSTG-1];

   // input is held back only when every stage is full and the output is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && (&vld)))
      else $error("input stalled with a bubble in the pipeline");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_special_angle: assert property (@(posedge clock) disable iff (reset)
      (vld[0] && word[0].special) |->
         (word[0].z == '0 || word[0].z == ANG_PI ||
          word[0].z == ANG_HALF_PI || word[0].z == -ANG_HALF_PI))
      else $error("special case with an unexpected angle");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bearing <= PI_Q13 && rsp_bearing >= -PI_Q13))
      else $error("bearing outside plus or minus pi");

   a_hold_in_flight: assert property (@(posedge clock) disable iff (reset)
      (vld[NSTG-2] && !adv[NSTG-1]) |=> vld[NSTG-2])
      else $error("word lost in front of a stalled output stage");

endmodule
